// ===== rtl/chv_pkg.sv =====
// Shared types, header offsets and boot logo table for the cartridge header verifier.
package chv_pkg;

   localparam int ADDR_BITS     = 23;
   localparam int LOGO_LEN      = 48;
   localparam int LOGO_IDX_BITS = $clog2(LOGO_LEN);
   localparam int ROM_SIZE_BITS = 24;

   localparam logic [ROM_SIZE_BITS-1:0] ROM_SIZE_RESET = ROM_SIZE_BITS'(32768);

   localparam logic [ADDR_BITS-1:0] LOGO_BASE = ADDR_BITS'(12'h104);
   localparam logic [ADDR_BITS-1:0] HDR_FIRST = ADDR_BITS'(12'h134);
   localparam logic [ADDR_BITS-1:0] HDR_LAST  = ADDR_BITS'(12'h14C);
   localparam logic [ADDR_BITS-1:0] HDR_CHECK = ADDR_BITS'(12'h14D);
   localparam logic [ADDR_BITS-1:0] GLB_HI    = ADDR_BITS'(12'h14E);
   localparam logic [ADDR_BITS-1:0] GLB_LO    = ADDR_BITS'(12'h14F);

   localparam logic [7:0] LOGO_TABLE [LOGO_LEN] = '{
      8'hCE, 8'hED, 8'h66, 8'h66, 8'hCC, 8'h0D, 8'h00, 8'h0B,
      8'h03, 8'h73, 8'h00, 8'h83, 8'h00, 8'h0C, 8'h00, 8'h0D,
      8'h00, 8'h08, 8'h11, 8'h1F, 8'h88, 8'h89, 8'h00, 8'h0E,
      8'hDC, 8'hCC, 8'h6E, 8'hE6, 8'hDD, 8'hDD, 8'hD9, 8'h99,
      8'hBB, 8'hBB, 8'h67, 8'h63, 8'h6E, 8'h0E, 8'hEC, 8'hCC,
      8'hDD, 8'hDC, 8'h99, 8'h9F, 8'hBB, 8'hB9, 8'h33, 8'h3E
   };

   typedef struct packed {
      logic [ADDR_BITS-1:0] byte_addr;
      logic [7:0]           byte_value;
      logic                 last_byte;
   } chv_req_type;

   typedef struct packed {
      logic logo_ok;
      logic header_ok;
      logic global_ok;
      logic all_ok;
   } chv_rsp_type;

   typedef struct packed {
      logic [7:0]  header_sum;
      logic [15:0] global_sum;
      logic        logo_match;
      logic [7:0]  header_expected;
      logic [15:0] global_expected;
   } chv_state_type;

   localparam chv_state_type STATE_RESET = '{
      header_sum:      8'h00,
      global_sum:      16'h0000,
      logo_match:      1'b1,
      header_expected: 8'h00,
      global_expected: 16'h0000
   };

endpackage

// ===== rtl/chv_byte_update.sv =====
// Per-byte update of the running checks and the pass flags they give.
module chv_byte_update (
   input  chv_pkg::chv_state_type            state,
   input  chv_pkg::chv_req_type              item,
   input  logic [chv_pkg::ROM_SIZE_BITS-1:0] rom_size,
   output chv_pkg::chv_state_type            state_next,
   output chv_pkg::chv_rsp_type              result
);

   logic [chv_pkg::ADDR_BITS-1:0]     addr;
   logic [chv_pkg::ADDR_BITS-1:0]     logo_off;
   logic [chv_pkg::LOGO_IDX_BITS-1:0] logo_idx;
   logic                              in_logo;
   logic                              in_header;
   logic                              in_rom;
   logic [7:0]                        b;

   assign addr      = item.byte_addr;
   assign b         = item.byte_value;
   assign logo_off  = addr - chv_pkg::LOGO_BASE;
   assign logo_idx  = logo_off[chv_pkg::LOGO_IDX_BITS-1:0];
   assign in_logo   = (addr >= chv_pkg::LOGO_BASE) &&
                      (logo_off < chv_pkg::ADDR_BITS'(chv_pkg::LOGO_LEN));
   assign in_header = (addr >= chv_pkg::HDR_FIRST) && (addr <= chv_pkg::HDR_LAST);
   assign in_rom    = (chv_pkg::ROM_SIZE_BITS'(addr) < rom_size) &&
                      (addr != chv_pkg::GLB_HI) && (addr != chv_pkg::GLB_LO);

   always_comb begin
      state_next = state;
      if (in_logo && (b != chv_pkg::LOGO_TABLE[logo_idx])) begin
         state_next.logo_match = 1'b0;
      end
      if (in_header) begin
         state_next.header_sum = state.header_sum - b - 8'd1;
      end
      if (addr == chv_pkg::HDR_CHECK) begin
         state_next.header_expected = b;
      end
      if (addr == chv_pkg::GLB_HI) begin
         state_next.global_expected[15:8] = b;
      end
      if (addr == chv_pkg::GLB_LO) begin
         state_next.global_expected[7:0] = b;
      end
      if (in_rom) begin
         state_next.global_sum = state.global_sum + {8'h00, b};
      end
   end

   always_comb begin
      result.logo_ok   = state_next.logo_match;
      result.header_ok = state_next.header_sum == state_next.header_expected;
      result.global_ok = state_next.global_sum == state_next.global_expected;
      result.all_ok    = result.logo_ok && result.header_ok && result.global_ok;
   end

endmodule

// ===== rtl/cartridge_header_verifier.sv =====
// Top level: streams image bytes through the header, logo and global checks.
//
//   port group   dir   beat carries              flow control
//   req_*        in    chv_req_type (one byte)   req_valid / req_stall
//   rsp_*        out   chv_rsp_type (verdict)    rsp_valid / rsp_stall
//   csr_*        in    rom_size_bytes, 24 bits   write enable only
//
// One byte per cycle while req_stall is low. A beat lands in the input
// register, then updates the running sums and, for the last byte, loads the
// result register, which drives rsp_valid.
// Reset (synchronous) clears valids and sums and sets rom size to 32768.
// Only a last byte waits on a held result; other bytes keep flowing while
// rsp_stall is high, so req_stall rises only for a last byte behind a full
// result register.
module cartridge_header_verifier (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  chv_pkg::chv_req_type              req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output chv_pkg::chv_rsp_type              rsp_data,
   input  logic                              csr_write_enable,
   input  logic [chv_pkg::ROM_SIZE_BITS-1:0] csr_write_data
);

   // config register
   logic [chv_pkg::ROM_SIZE_BITS-1:0] rom_size_ff;

   // input register
   logic                  in_valid_ff;
   logic                  in_valid_in;
   chv_pkg::chv_req_type  in_item_ff;

   // running check state
   chv_pkg::chv_state_type state_ff;
   chv_pkg::chv_state_type state_in;
   chv_pkg::chv_state_type state_next;

   // result register
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   chv_pkg::chv_rsp_type rsp_data_ff;
   chv_pkg::chv_rsp_type result;

   logic advance;
   logic in_load;
   logic emit;

   chv_byte_update u_update (
      .state      (state_ff),
      .item       (in_item_ff),
      .rom_size   (rom_size_ff),
      .state_next (state_next),
      .result     (result)
   );

   // a held byte moves on unless it is last and the result slot is blocked
   assign advance   = in_valid_ff &&
                      !(in_item_ff.last_byte && rsp_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign in_load   = !req_stall;
   assign emit      = advance && in_item_ff.last_byte;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (in_load) begin
         in_valid_in = req_valid;
      end
   end

   always_comb begin
      state_in = state_ff;
      if (advance) begin
         state_in = in_item_ff.last_byte ? chv_pkg::STATE_RESET : state_next;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rom_size_ff  <= chv_pkg::ROM_SIZE_RESET;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= chv_pkg::STATE_RESET;
      end else begin
         if (csr_write_enable) begin
            rom_size_ff <= csr_write_data;
         end
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (in_load) begin
         in_item_ff <= req_data;
      end
      if (emit) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // stall is only raised against a held last byte
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && in_item_ff.last_byte && rsp_valid_ff))
      else $error("req_stall without a blocked last byte");

   // a delivered verdict leaves the running checks cleared
   a_clear_after_emit: assert property (@(posedge clock) disable iff (reset)
      emit |=> (state_ff == chv_pkg::STATE_RESET))
      else $error("check state not cleared after verdict");

   // ordinary bytes flowing past a held result do not disturb it
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall && !emit) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("held result changed");
`endif

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for cartridge_header_verifier: random images, random stalls.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // Header layout, kept apart from the package so the check stays independent
   localparam logic [22:0] LOGO_AT     = 23'h104;
   localparam logic [22:0] HDR_SPAN_LO = 23'h134;
   localparam logic [22:0] HDR_SPAN_HI = 23'h14C;
   localparam logic [22:0] HDR_SUM_AT  = 23'h14D;
   localparam logic [22:0] GSUM_HI_AT  = 23'h14E;
   localparam logic [22:0] GSUM_LO_AT  = 23'h14F;
   localparam int          MAX_REPORTS = 10;

   logic [7:0] boot_logo [0:47] = '{
      8'hCE, 8'hED, 8'h66, 8'h66, 8'hCC, 8'h0D, 8'h00, 8'h0B,
      8'h03, 8'h73, 8'h00, 8'h83, 8'h00, 8'h0C, 8'h00, 8'h0D,
      8'h00, 8'h08, 8'h11, 8'h1F, 8'h88, 8'h89, 8'h00, 8'h0E,
      8'hDC, 8'hCC, 8'h6E, 8'hE6, 8'hDD, 8'hDD, 8'hD9, 8'h99,
      8'hBB, 8'hBB, 8'h67, 8'h63, 8'h6E, 8'h0E, 8'hEC, 8'hCC,
      8'hDD, 8'hDC, 8'h99, 8'h9F, 8'hBB, 8'hB9, 8'h33, 8'h3E
   };

   // Every block input starts at a known value
   logic                 clock            = 1'b0;
   logic                 reset            = 1'b1;
   logic                 req_valid        = 1'b0;
   logic                 req_stall;
   chv_pkg::chv_req_type req_data         = '0;
   logic                 rsp_valid;
   logic                 rsp_stall        = 1'b0;
   chv_pkg::chv_rsp_type rsp_data;
   logic                 csr_write_enable = 1'b0;
   logic [23:0]          csr_write_data   = '0;

   cartridge_header_verifier dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Predictor copy of the ROM size register and the running image state
   logic [23:0] rom_limit  = 24'd32768;
   logic [7:0]  hdr_acc    = 8'h00;
   logic [15:0] glb_acc    = 16'h0000;
   logic        logo_clean = 1'b1;
   logic [7:0]  hdr_want   = 8'h00;
   logic [15:0] glb_want   = 16'h0000;

   chv_pkg::chv_req_type byte_q [$];     // image bytes waiting for the driver
   chv_pkg::chv_rsp_type verdict_q [$];  // verdicts owed by the block, oldest first

   int cycle_no      = 0;
   int bytes_sent    = 0;
   int verdicts_seen = 0;
   int mismatches    = 0;
   int settings_run  = 1;

   always #6 clock = ~clock;

   // Synchronous reset, high from the start, then released and never raised again
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) cycle_no <= cycle_no + 1;

   // Roughly 7% idle cycles on each side, none at all inside a quiet window
   function automatic bit take_break();
      return !(cycle_no >= 600 && cycle_no < 1400) && ($urandom_range(0, 99) < 7);
   endfunction

   // Advance the image state by one accepted byte; a last byte owes a verdict
   // and returns the state to its clean start, the ROM size stays.
   task automatic track_byte(input chv_pkg::chv_req_type beat);
      chv_pkg::chv_rsp_type verdict;
      logic [22:0] a;
      logic [7:0]  v;
      a = beat.byte_addr;
      v = beat.byte_value;
      if (a >= LOGO_AT && a < LOGO_AT + 23'd48 && v != boot_logo[6'(a - LOGO_AT)])
         logo_clean = 1'b0;
      if (a >= HDR_SPAN_LO && a <= HDR_SPAN_HI)
         hdr_acc = hdr_acc - v - 8'd1;
      if (a == HDR_SUM_AT) hdr_want = v;
      if (a == GSUM_HI_AT) glb_want[15:8] = v;
      if (a == GSUM_LO_AT) glb_want[7:0] = v;
      if ({1'b0, a} < rom_limit && a != GSUM_HI_AT && a != GSUM_LO_AT)
         glb_acc = glb_acc + {8'h00, v};
      if (beat.last_byte) begin
         verdict.logo_ok   = logo_clean;
         verdict.header_ok = (hdr_acc == hdr_want);
         verdict.global_ok = (glb_acc == glb_want);
         verdict.all_ok    = verdict.logo_ok & verdict.header_ok & verdict.global_ok;
         verdict_q.push_back(verdict);
         hdr_acc    = 8'h00;
         glb_acc    = 16'h0000;
         logo_clean = 1'b1;
         hdr_want   = 8'h00;
         glb_want   = 16'h0000;
      end
   endtask

   // Driver: predicts each beat as it is accepted, then loads the next one.
   // A stalled beat is held as is; valid drops only when the slot is free.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            track_byte(req_data);
            bytes_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (byte_q.size() != 0 && !take_break()) begin
               req_valid <= 1'b1;
               req_data  <= byte_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result side back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= take_break();
      end
   end

   // Monitor: every accepted verdict beat is matched against the oldest one owed
   always @(posedge clock) begin
      chv_pkg::chv_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         verdicts_seen++;
         if (verdict_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("[%0t] unexpected verdict l=%0b h=%0b g=%0b all=%0b", $realtime,
                        rsp_data.logo_ok, rsp_data.header_ok, rsp_data.global_ok,
                        rsp_data.all_ok);
         end else begin
            want = verdict_q.pop_front();
            if (rsp_data.logo_ok !== want.logo_ok || rsp_data.header_ok !== want.header_ok ||
                rsp_data.global_ok !== want.global_ok || rsp_data.all_ok !== want.all_ok) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("[%0t] verdict mismatch: expected l=%0b h=%0b g=%0b all=%0b,",
                           $realtime, want.logo_ok, want.header_ok, want.global_ok,
                           want.all_ok, " got l=%0b h=%0b g=%0b all=%0b",
                           rsp_data.logo_ok, rsp_data.header_ok,
                           rsp_data.global_ok, rsp_data.all_ok);
            end
         end
      end
   end

   task automatic queue_beat(input logic [22:0] addr, input logic [7:0] value,
                             input logic last);
      chv_pkg::chv_req_type beat;
      beat.byte_addr  = addr;
      beat.byte_value = value;
      beat.last_byte  = last;
      byte_q.push_back(beat);
   endtask

   // Random byte: anywhere in the address space, around the header, around
   // the ROM size boundary, or in the first 32 KiB.
   function automatic chv_pkg::chv_req_type random_beat();
      chv_pkg::chv_req_type beat;
      beat.byte_value = 8'($urandom_range(0, 255));
      beat.last_byte  = 1'b0;
      case ($urandom_range(0, 3))
         0: beat.byte_addr = 23'($urandom_range(0, 23'h7FFFFF));
         1: beat.byte_addr = 23'h100 + 23'($urandom_range(0, 8'h4F));
         2: begin
            if (rom_limit == 0 || rom_limit > 24'h800000)
               beat.byte_addr = 23'($urandom_range(0, 23'h7FFFFF));
            else if (rom_limit == 24'h800000)
               beat.byte_addr = 23'h7FFFFF;
            else
               beat.byte_addr = 23'(rom_limit - 24'd1 + 24'($urandom_range(0, 1)));
         end
         default: beat.byte_addr = 23'($urandom_range(0, 16'h7FFF));
      endcase
      return beat;
   endfunction

   // One image, closed by a last byte. A well-formed image carries the logo,
   // a header with a correct checksum and a correct global word, sometimes
   // with one of the three broken on purpose. Otherwise a short scatter of
   // random bytes that lands on header fields now and then.
   task automatic queue_image(input bit well_formed);
      chv_pkg::chv_req_type img [$];
      chv_pkg::chv_req_type beat;
      logic [7:0]  hdr;
      logic [15:0] gsum;
      int          flaw;
      int          hi_at;
      if (!well_formed) begin
         repeat ($urandom_range(1, 12)) img.push_back(random_beat());
      end else begin
         flaw = $urandom_range(0, 7);  // 0 logo, 1 header, 2 global, else clean
         repeat ($urandom_range(0, 6)) begin
            beat = random_beat();
            // keep filler off the header so only the chosen flaw shows
            if (beat.byte_addr >= LOGO_AT && beat.byte_addr <= GSUM_LO_AT)
               beat.byte_addr = beat.byte_addr + 23'h50;
            img.push_back(beat);
         end
         beat.last_byte = 1'b0;
         for (int i = 0; i < 48; i++) begin
            beat.byte_addr  = LOGO_AT + 23'(i);
            beat.byte_value = boot_logo[i];
            img.push_back(beat);
         end
         if (flaw == 0)
            img[img.size() - 1 - $urandom_range(0, 47)].byte_value ^= 8'($urandom_range(1, 255));
         hdr = 8'h00;
         for (int a = HDR_SPAN_LO; a <= HDR_SPAN_HI; a++) begin
            beat.byte_addr  = 23'(a);
            beat.byte_value = 8'($urandom_range(0, 255));
            hdr = hdr - beat.byte_value - 8'd1;
            img.push_back(beat);
         end
         beat.byte_addr  = HDR_SUM_AT;
         beat.byte_value = (flaw == 1) ? hdr ^ 8'($urandom_range(1, 255)) : hdr;
         img.push_back(beat);
         hi_at = img.size();
         beat.byte_addr = GSUM_HI_AT;
         img.push_back(beat);
         beat.byte_addr = GSUM_LO_AT;
         img.push_back(beat);
         repeat ($urandom_range(0, 4)) img.push_back(random_beat());
         gsum = 16'h0000;
         foreach (img[i])
            if ({1'b0, img[i].byte_addr} < rom_limit && img[i].byte_addr != GSUM_HI_AT &&
                img[i].byte_addr != GSUM_LO_AT)
               gsum = gsum + {8'h00, img[i].byte_value};
         if (flaw == 2) gsum ^= 16'($urandom_range(1, 16'hFFFF));
         img[hi_at].byte_value     = gsum[15:8];
         img[hi_at + 1].byte_value = gsum[7:0];
      end
      img[img.size() - 1].last_byte = 1'b1;
      foreach (img[i]) byte_q.push_back(img[i]);
   endtask

   // Random part of one ROM size setting: mostly well-formed images, the
   // rest scattered bytes, until enough beats and verdicts are lined up.
   // Filled at the falling edge, in one go, so the driver never sees half an image.
   task automatic run_random(input int beats_wanted);
      int beats;
      int images;
      int before_fill;
      beats  = 0;
      images = 0;
      @(negedge clock);
      while (beats < beats_wanted || images < 2) begin
         before_fill = byte_q.size();
         queue_image($urandom_range(0, 99) < 60);
         beats += byte_q.size() - before_fill;
         images++;
      end
   endtask

   // Idle point: all beats taken, all verdicts back, pipeline flushed
   task automatic drain();
      while (byte_q.size() != 0 || verdict_q.size() != 0 || req_valid) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_rom_size(input logic [23:0] size);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= size;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      rom_limit = size;
      settings_run++;
   endtask

   initial begin
      logic [23:0] size_plan [$];
      size_plan = '{24'h800000, 24'h000000, 24'hFFFFFF,
                    24'($urandom_range(32768, 24'h800000)), 24'h000140, 24'h008000};
      @(negedge clock);
      while (reset) @(negedge clock);

      // Directed part, under the reset ROM size of 32 KiB
      queue_beat(23'h000000, 8'h00, 1'b1);    // image of one byte at the lowest address
      queue_beat(HDR_SUM_AT, 8'h00, 1'b1);    // lone last byte, every check passes on empties
      queue_beat(23'h7FFFFF, 8'hFF, 1'b0);    // top address, outside the global sum
      queue_beat(GSUM_HI_AT, 8'hAB, 1'b0);
      queue_beat(GSUM_HI_AT, 8'h00, 1'b0);    // repeat overwrites the latched high byte
      queue_beat(GSUM_LO_AT, 8'hFF, 1'b0);
      queue_beat(LOGO_AT, 8'hCE, 1'b0);
      queue_beat(LOGO_AT, 8'h00, 1'b0);       // same logo slot again, now wrong
      queue_beat(23'h000133, 8'h3E, 1'b0);    // last logo slot
      queue_beat(HDR_SPAN_LO, 8'hFF, 1'b0);
      queue_beat(HDR_SPAN_HI, 8'h00, 1'b0);
      queue_beat(HDR_SUM_AT, 8'h12, 1'b0);
      queue_beat(HDR_SUM_AT, 8'h34, 1'b0);    // later check byte wins
      queue_beat(23'h007FFF, 8'h80, 1'b0);    // just inside the ROM size
      queue_beat(23'h008000, 8'h7F, 1'b0);    // first address outside it
      queue_beat(23'h000103, 8'h55, 1'b1);    // last byte just below the logo
      queue_beat(23'h0001FF, 8'hFF, 1'b1);    // missing header fields: logo and header pass, global sum does not

      run_random(150);
      drain();

      // Remaining ROM sizes: the full 8 MiB address space, zero, the top of the field, a random
      // one, a small size that cuts through the header, and the reset value written back
      foreach (size_plan[i]) begin
         set_rom_size(size_plan[i]);
         run_random(150);
         drain();
      end

      repeat (10) @(posedge clock);
      $display("Streamed %0d image bytes over %0d ROM size settings,", bytes_sent, settings_run);
      $display("checked %0d verdicts, %0d mismatches.", verdicts_seen, mismatches);
      if (mismatches == 0 && verdict_q.size() == 0) begin
         $display("PASS cartridge_header_verifier");
      end else begin
         $display("FAIL cartridge_header_verifier");
      end
      $finish;
   end

   // Hang guard: far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("FAIL cartridge_header_verifier");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/chv_pkg.sv
rtl/chv_byte_update.sv
rtl/cartridge_header_verifier.sv
sim/tb_top.sv
